@@ design/alcf_pkg.sv @@
// ---------------------------------------------------------------------------
// alcf_pkg
// Shared types, constants and codes for the linear crossfade core.
// ---------------------------------------------------------------------------
`default_nettype none

package alcf_pkg;

  // q31 unity gain and saturation limits
  localparam logic [31:0] Q31_UNITY = 32'h7FFF_FFFF;
  localparam logic signed [63:0] MAX_32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN_32 = -64'sh0000_0000_8000_0000;
  localparam logic signed [31:0] MAX_16 = 32'sh0000_7FFF;
  localparam logic signed [31:0] MIN_16 = -32'sh0000_8000;

  // register bus geometry
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_SAMPLE_WIDTH = 2'd0;
  localparam logic [1:0] REG_CONVERGE     = 2'd1;
  localparam logic [1:0] REG_TOTAL        = 2'd2;
  localparam logic [1:0] REG_STEP         = 2'd3;

  // reported phase of an item, also selects the output source
  localparam logic [1:0] FP_CONVERGE = 2'd0;
  localparam logic [1:0] FP_FADE     = 2'd1;
  localparam logic [1:0] FP_PASS_NEW = 2'd2;

  // internal period state
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CONV = 2'd1;
  localparam logic [1:0] PH_FADE = 2'd2;

  typedef struct packed {
    logic        sample_width;
    logic [23:0] converge_samples;
    logic [23:0] period_samples;
    logic [30:0] ramp_step;
  } cfg_t;

  // per-item decision handed from the control to the mixer
  typedef struct packed {
    logic [1:0]  fade_phase;
    logic        fade_done;
    logic [31:0] up_gain;
    logic [31:0] down_gain;
  } ctrl_t;

endpackage

`default_nettype wire

@@ design/audio_linear_crossfade_core.sv @@
// ---------------------------------------------------------------------------
// audio_linear_crossfade_core
// Linear q31 crossfade from an old to a new sample source.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  channel: one old/new sample pair per item, with a block-end mark.
//   out_* channel: one mixed sample per item, with its fade phase and a
//                  done pulse on the item that completes the total period.
//   Configuration (sample width, convergence length, total period, ramp step)
//   is for the user to write through the apb-style port while the block is
//   idle, unchecked; pready is always high, reads return the register values.
// Timing:
//   An accepted item is held in an input register and moves into the output
//   register when the output stage is empty or taken. One item per cycle is
//   sustained while out_ready is high; the two 32x32 gain multiplies and the
//   ramp update all sit in a single stage.
// Reset:
//   Registers return to their defaults, the period count to zero and the
//   ramps to up = 0, down = q31 one; both pipeline stages are emptied.
// Stall:
//   While out_ready is low the result is held; one more item may still be
//   taken into the input register, after which in_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module audio_linear_crossfade_core
  import alcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // input item channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [31:0] in_old_sample,
  input  wire logic signed [31:0] in_new_sample,
  input  wire logic              in_block_end,
  // result item channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [31:0]     out_mixed_sample,
  output logic [1:0]             out_fade_phase,
  output logic                   out_fade_done
);

  cfg_t  cfg;
  ctrl_t ctrl;

  logic               s1_valid_r, s1_valid_nxt;
  logic signed [31:0] s1_old_r;
  logic signed [31:0] s1_new_r;
  logic               s1_end_r;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_mixed_r;
  logic [1:0]         out_phase_r;
  logic               out_done_r;
  logic signed [31:0] mixed;
  logic               advance;
  logic               item_fire;
  logic               in_fire;

  alcf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: output stage frees when empty or taken
  assign advance   = !out_valid_r || out_ready;
  assign item_fire = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;

  alcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_fire (item_fire),
    .block_end (s1_end_r),
    .ctrl      (ctrl)
  );

  alcf_mix u_mix (
    .sample_width (cfg.sample_width),
    .old_sample   (s1_old_r),
    .new_sample   (s1_new_r),
    .ctrl         (ctrl),
    .mixed_sample (mixed)
  );

  // stage valid bits
  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (item_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = item_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_old_r <= in_old_sample;
      s1_new_r <= in_new_sample;
      s1_end_r <= in_block_end;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (item_fire) begin
      out_mixed_r <= mixed;
      out_phase_r <= ctrl.fade_phase;
      out_done_r  <= ctrl.fade_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_mixed_r;
  assign out_fade_phase   = out_phase_r;
  assign out_fade_done    = out_done_r;

endmodule

`default_nettype wire

@@ design/alcf_cfg.sv @@
// ---------------------------------------------------------------------------
// alcf_cfg
// Register file behind the apb-style configuration port.
// ---------------------------------------------------------------------------
`default_nettype none

module alcf_cfg
  import alcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SAMPLE_WIDTH: cfg_nxt.sample_width     = pwdata[0];
        REG_CONVERGE:     cfg_nxt.converge_samples = pwdata[23:0];
        REG_TOTAL:        cfg_nxt.period_samples   = pwdata[23:0];
        REG_STEP:         cfg_nxt.ramp_step        = pwdata[30:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_width     <= 1'b0;
      cfg_r.converge_samples <= 24'd0;
      cfg_r.period_samples   <= 24'd1;
      cfg_r.ramp_step        <= 31'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_WIDTH: prdata = {31'd0, cfg_r.sample_width};
      REG_CONVERGE:     prdata = {8'd0, cfg_r.converge_samples};
      REG_TOTAL:        prdata = {8'd0, cfg_r.period_samples};
      REG_STEP:         prdata = {1'b0, cfg_r.ramp_step};
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/alcf_ctrl.sv @@
// ---------------------------------------------------------------------------
// alcf_ctrl
// Period counter, phase tracking and q31 gain ramps.
// ---------------------------------------------------------------------------
`default_nettype none

module alcf_ctrl
  import alcf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  item_fire,
  input  wire logic  block_end,
  output ctrl_t      ctrl
);

  logic [23:0] cnt_r, cnt_nxt;
  logic [31:0] up_r, up_nxt;
  logic [31:0] down_r, down_nxt;
  logic [1:0]  phase_r, phase_nxt;

  logic        past_total;
  logic        converging;
  logic [23:0] cnt_inc;
  logic [23:0] cnt_after;
  logic [31:0] up_eff;
  logic [31:0] down_eff;
  logic [32:0] up_sum;
  logic [31:0] up_step;

  assign past_total = cnt_r >= cfg.period_samples;
  assign converging = cnt_r < cfg.converge_samples;
  assign cnt_inc    = cnt_r + 24'd1;

  // ramps restart on the first fading item of a period
  assign up_eff   = (phase_r == PH_FADE) ? up_r : 32'd0;
  assign down_eff = (phase_r == PH_FADE) ? down_r : Q31_UNITY;

  // saturating ramp step
  assign up_sum  = {1'b0, up_eff} + {2'b00, cfg.ramp_step};
  assign up_step = (up_sum > {1'b0, Q31_UNITY}) ? Q31_UNITY : up_sum[31:0];

  // decision for the current item and next state
  always_comb begin
    cnt_nxt         = cnt_r;
    up_nxt          = up_r;
    down_nxt        = down_r;
    phase_nxt       = phase_r;
    ctrl.fade_done  = 1'b0;
    ctrl.up_gain    = up_eff;
    ctrl.down_gain  = down_eff;
    cnt_after       = cnt_r;
    if (past_total) begin
      ctrl.fade_phase = FP_PASS_NEW;
    end else begin
      if (converging) begin
        ctrl.fade_phase = FP_CONVERGE;
        phase_nxt       = PH_CONV;
      end else begin
        ctrl.fade_phase = FP_FADE;
        phase_nxt       = PH_FADE;
        up_nxt          = up_step;
        down_nxt        = Q31_UNITY - up_step;
      end
      cnt_after      = cnt_inc;
      cnt_nxt        = cnt_inc;
      ctrl.fade_done = (cnt_inc == cfg.period_samples);
    end
    // period restart at the end of a block once the period is over
    if (block_end && (cnt_after >= cfg.period_samples)) begin
      cnt_nxt   = 24'd0;
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 24'd0;
      up_r    <= 32'd0;
      down_r  <= Q31_UNITY;
      phase_r <= PH_IDLE;
    end else if (item_fire) begin
      cnt_r   <= cnt_nxt;
      up_r    <= up_nxt;
      down_r  <= down_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/alcf_mix.sv @@
// ---------------------------------------------------------------------------
// alcf_mix
// Sample mixer: gain products, 16/32-bit scaling and the lower floor.
// ---------------------------------------------------------------------------
`default_nettype none

module alcf_mix
  import alcf_pkg::*;
(
  input  wire logic               sample_width,
  input  wire logic signed [31:0] old_sample,
  input  wire logic signed [31:0] new_sample,
  input  wire ctrl_t              ctrl,
  output logic signed [31:0]      mixed_sample
);

  logic signed [31:0] o_s;
  logic signed [31:0] n_s;
  logic signed [31:0] down_s;
  logic signed [31:0] up_s;
  logic signed [63:0] prod_o;
  logic signed [63:0] prod_n;
  logic signed [63:0] sum16;
  logic signed [31:0] sat32;
  logic signed [31:0] shr16;
  logic signed [31:0] y16;
  logic signed [64:0] acc32;
  logic signed [31:0] y32;
  logic signed [31:0] y_mix;
  logic signed [31:0] lo;

  // sign-extend from the active sample width
  assign o_s = sample_width ? old_sample : {{16{old_sample[15]}}, old_sample[15:0]};
  assign n_s = sample_width ? new_sample : {{16{new_sample[15]}}, new_sample[15:0]};

  assign down_s = ctrl.down_gain;
  assign up_s   = ctrl.up_gain;

  assign prod_o = o_s * down_s;
  assign prod_n = n_s * up_s;

  // 16-bit path: per-product shift, saturate to 32, shift, saturate to 16
  always_comb begin
    sum16 = (prod_o >>> 16) + (prod_n >>> 16);
    if (sum16 > MAX_32) begin
      sat32 = MAX_32[31:0];
    end else if (sum16 < MIN_32) begin
      sat32 = MIN_32[31:0];
    end else begin
      sat32 = sum16[31:0];
    end
    shr16 = sat32 >>> 15;
    if (shr16 > MAX_16) begin
      y16 = MAX_16;
    end else if (shr16 < MIN_16) begin
      y16 = MIN_16;
    end else begin
      y16 = shr16;
    end
  end

  // 32-bit path: exact sum, shift by 31, wrap to 32 bits
  assign acc32 = {prod_o[63], prod_o} + {prod_n[63], prod_n};
  assign y32   = acc32[62:31];

  // output never below the smaller input
  assign lo    = (o_s < n_s) ? o_s : n_s;
  assign y_mix = sample_width ? y32 : y16;

  // source select
  always_comb begin
    case (ctrl.fade_phase)
      FP_CONVERGE: mixed_sample = o_s;
      FP_PASS_NEW: mixed_sample = n_s;
      default:     mixed_sample = (y_mix < lo) ? lo : y_mix;
    endcase
  end

endmodule

`default_nettype wire
